@@ sv/gcs_pkg.sv @@
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared constants and codes of the genotype column standardizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gcs_pkg;

  localparam int MaxIndividuals = 4096;
  localparam int IdxW           = $clog2(MaxIndividuals);
  localparam int CountW         = IdxW + 1;
  localparam int AlleleSumW     = 14;
  localparam int SquareSumW     = 15;
  localparam int MeanW          = 18;
  localparam int ScaleW         = 32;
  localparam int ValueW         = 25;
  localparam int StatusW        = 2;
  localparam int DosageW        = 2;

  localparam int FracBits       = 48;
  localparam int NumW           = 2 * IdxW + 1;
  localparam int DivW           = NumW + FracBits;
  localparam int DenW           = SquareSumW + CountW;
  localparam int MeanNumW       = AlleleSumW + 17;
  localparam int ProdW          = MeanW + ScaleW;
  localparam int StepW          = 7;

  localparam logic [MeanW-1:0]   MeanMax   = MeanW'(131072);
  localparam logic [ValueW-1:0]  ValPosMax = ValueW'(16777215);
  localparam logic [DosageW-1:0] MissingCode = 2'd3;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusMissing  = 2'd1;
  localparam logic [StatusW-1:0] StatusZeroVar  = 2'd2;

  localparam logic KindSummary = 1'b0;
  localparam logic KindValue   = 1'b1;

endpackage

`default_nettype wire

@@ sv/gcs_ram.sv @@
// ----------------------------------------------------------------------------
// gcs_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcs_ram #(
  parameter int Width = 2,
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ sv/genotype_column_standardizer.sv @@
// ----------------------------------------------------------------------------
// genotype_column_standardizer
// Accumulates one genotype column, derives mean and inverse standard
// deviation with bit-serial divide and square root, and returns centered
// scaled dosages through a bit-serial multiplier.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  in      | in_valid/in_ready, command, individual, | into block
//          | allele_first, allele_second             |
//  out     | out_valid/out_ready, result_kind, ...   | out of block
//  cfg     | cfg_valid/cfg_ready, cfg_data           | into block
//
// Start and load are accepted while idle and may follow back to back.
// Read runs RAM read, an 18-step shift-add multiply, round and output;
// a missing individual goes from RAM read straight to output.
// Finish runs product setup, 31-step and 73-step serial
// divides and a 32-step square root, one bit per cycle, plus checks and output.
// A waiting result holds in the output register; input stalls only while
// a read or finish is in progress. Synchronous active-low reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module genotype_column_standardizer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_command,
  input  wire logic [gcs_pkg::IdxW-1:0]           in_individual,
  input  wire logic                               in_allele_first,
  input  wire logic                               in_allele_second,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_result_kind,
  output logic signed [gcs_pkg::ValueW-1:0]      out_standardized_value,
  output logic      [gcs_pkg::MeanW-1:0]         out_mean_value,
  output logic      [gcs_pkg::ScaleW-1:0]        out_scale_value,
  output logic      [gcs_pkg::StatusW-1:0]       out_status,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [gcs_pkg::CountW-1:0]         cfg_data
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_RDATA  = 10'b00_0000_0010,
    ST_MUL    = 10'b00_0000_0100,
    ST_ROUND  = 10'b00_0000_1000,
    ST_FPROD  = 10'b00_0001_0000,
    ST_DMEAN  = 10'b00_0010_0000,
    ST_DCHK   = 10'b00_0100_0000,
    ST_DSCALE = 10'b00_1000_0000,
    ST_SCHK   = 10'b01_0000_0000,
    ST_PUSH   = 10'b10_0000_0000
  } state_t;

  localparam int CW = gcs_pkg::CountW;
  localparam int DW = gcs_pkg::DivW;
  localparam int NW = gcs_pkg::DenW;

  state_t state_r, state_nxt;

  logic [CW-1:0]                   num_ind_r;
  logic [gcs_pkg::AlleleSumW-1:0]  allele_sum_r;
  logic [gcs_pkg::SquareSumW-1:0]  square_sum_r;
  logic [CW-1:0]                   missing_r;
  logic [gcs_pkg::MeanW-1:0]       mean_r;
  logic [gcs_pkg::ScaleW-1:0]      scale_r;

  logic [CW-1:0]                   cnt_r;
  logic [gcs_pkg::IdxW-1:0]        nm1_r;
  logic [NW-1:0]                   prod_sq_r;
  logic [NW-1:0]                   prod_as_r;
  logic [gcs_pkg::NumW-1:0]        num_r;

  logic [NW-1:0]                   rem_r;
  logic [DW-1:0]                   dq_r;
  logic [NW-1:0]                   den_r;
  logic [gcs_pkg::StepW-1:0]       step_r;
  logic                            sqrt_mode_r;
  logic [gcs_pkg::ScaleW+1:0]      srem_r;
  logic [gcs_pkg::ScaleW-1:0]      root_r;

  logic [gcs_pkg::ProdW:0]         mp_r;
  logic                            neg_r;

  logic                            res_kind_r;
  logic [gcs_pkg::ValueW-1:0]      res_val_r;
  logic [gcs_pkg::StatusW-1:0]     res_status_r;

  logic                            out_valid_r;
  logic                            out_kind_r;
  logic [gcs_pkg::ValueW-1:0]      out_val_r;
  logic [gcs_pkg::MeanW-1:0]       out_mean_r;
  logic [gcs_pkg::ScaleW-1:0]      out_scale_r;
  logic [gcs_pkg::StatusW-1:0]     out_status_r;

  logic                            in_acc;
  logic                            load_en;
  logic                            is_missing;
  logic [gcs_pkg::DosageW-1:0]     dosage_in;
  logic [gcs_pkg::DosageW-1:0]     ram_wdata;
  logic [gcs_pkg::DosageW-1:0]     ram_rdata;
  logic [CW-1:0]                   n_eff;
  logic [CW-1:0]                   cnt_w;
  logic                            last_step;

  logic [NW:0]                     div_trial;
  logic                            div_ge;
  logic [NW-1:0]                   div_rem;
  logic [gcs_pkg::ScaleW+3:0]      sq_t;
  logic [gcs_pkg::ScaleW+3:0]      sq_trial;
  logic                            sq_ge;
  logic [gcs_pkg::ScaleW-1:0]      root_nxt;

  logic [NW:0]                     dd_w;
  logic                            dd_nonpos;
  logic [gcs_pkg::MeanNumW-1:0]    mean_num;
  logic [gcs_pkg::MeanNumW-1:0]    mean_q;

  logic [gcs_pkg::MeanW-1:0]       dval;
  logic                            rd_neg;
  logic [gcs_pkg::MeanW-1:0]       rd_mag;
  logic [gcs_pkg::ScaleW+1:0]      mul_sum;
  logic [gcs_pkg::ProdW-1:0]       rnd_sum;
  logic [gcs_pkg::ValueW:0]        rnd;
  logic [gcs_pkg::ValueW-1:0]      val_pos;
  logic [gcs_pkg::ValueW-1:0]      val_neg;
  logic                            push_go;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign cfg_ready = 1'b1;

  assign is_missing = ~in_allele_first & in_allele_second;
  assign dosage_in  = {1'b0, in_allele_first} + {1'b0, in_allele_second};
  assign ram_wdata  = is_missing ? gcs_pkg::MissingCode : dosage_in;
  assign load_en    = in_acc & (in_command == gcs_pkg::CMD_LOAD);

  gcs_ram #(
    .Width (gcs_pkg::DosageW),
    .Depth (gcs_pkg::MaxIndividuals)
  ) u_ram (
    .clk   (clk),
    .we    (load_en),
    .addr  (in_individual),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    n_eff = num_ind_r;
    if (num_ind_r < CW'(2)) begin
      n_eff = CW'(2);
    end else if (num_ind_r > CW'(gcs_pkg::MaxIndividuals)) begin
      n_eff = CW'(gcs_pkg::MaxIndividuals);
    end
  end
  assign cnt_w = n_eff - missing_r;

  assign last_step = (step_r == '0);

  assign div_trial = {rem_r, dq_r[DW-1]};
  assign div_ge    = (div_trial >= {1'b0, den_r});
  assign div_rem   = div_ge ? NW'(div_trial - {1'b0, den_r}) : div_trial[NW-1:0];

  assign sq_t     = {srem_r, dq_r[DW-1:DW-2]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign sq_ge    = (sq_t >= sq_trial);
  assign root_nxt = {root_r[gcs_pkg::ScaleW-2:0], sq_ge};

  assign dd_w      = {1'b0, prod_sq_r} - {1'b0, prod_as_r};
  assign dd_nonpos = dd_w[NW] | (dd_w == '0);
  assign mean_num  = {allele_sum_r, 17'b0} + gcs_pkg::MeanNumW'(cnt_r);
  assign mean_q    = dq_r[gcs_pkg::MeanNumW-1:0];

  assign dval   = {ram_rdata, 16'b0};
  assign rd_neg = (mean_r > dval);
  assign rd_mag = rd_neg ? (mean_r - dval) : (dval - mean_r);

  assign mul_sum = {1'b0, mp_r[gcs_pkg::ProdW:gcs_pkg::MeanW]} +
                   (mp_r[0] ? {2'b00, scale_r} : '0);
  assign rnd_sum = mp_r[gcs_pkg::ProdW-1:0] + gcs_pkg::ProdW'(1 << 23);
  assign rnd     = rnd_sum[gcs_pkg::ProdW-1:24];
  assign val_pos = (rnd > {1'b0, gcs_pkg::ValPosMax}) ? gcs_pkg::ValPosMax
                 : rnd[gcs_pkg::ValueW-1:0];
  assign val_neg = (rnd > {1'b0, gcs_pkg::ValPosMax}) ? ~gcs_pkg::ValPosMax
                 : (gcs_pkg::ValueW'(0) - rnd[gcs_pkg::ValueW-1:0]);

  assign push_go = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_command == gcs_pkg::CMD_READ) begin
          state_nxt = ST_RDATA;
        end else if (in_acc && in_command == gcs_pkg::CMD_FINISH) begin
          state_nxt = (missing_r >= n_eff) ? ST_PUSH : ST_FPROD;
        end
      end
      ST_RDATA:  state_nxt = (ram_rdata == gcs_pkg::MissingCode) ? ST_PUSH : ST_MUL;
      ST_MUL:    if (last_step) state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_PUSH;
      ST_FPROD:  state_nxt = ST_DMEAN;
      ST_DMEAN:  if (last_step) state_nxt = ST_DCHK;
      ST_DCHK:   state_nxt = dd_nonpos ? ST_PUSH : ST_DSCALE;
      ST_DSCALE: begin
        if (last_step) begin
          state_nxt = sqrt_mode_r ? ST_PUSH : ST_SCHK;
        end
      end
      ST_SCHK:   state_nxt = (dq_r[DW-1:64] != '0) ? ST_PUSH : ST_DSCALE;
      ST_PUSH:   if (push_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      num_ind_r    <= CW'(gcs_pkg::MaxIndividuals);
      allele_sum_r <= '0;
      square_sum_r <= '0;
      missing_r    <= '0;
      mean_r       <= '0;
      scale_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        num_ind_r <= cfg_data;
      end
      if (in_acc && in_command == gcs_pkg::CMD_START) begin
        allele_sum_r <= '0;
        square_sum_r <= '0;
        missing_r    <= '0;
      end
      if (load_en) begin
        if (is_missing) begin
          missing_r <= missing_r + CW'(1);
        end else begin
          allele_sum_r <= allele_sum_r + gcs_pkg::AlleleSumW'(dosage_in);
          square_sum_r <= square_sum_r +
                          gcs_pkg::SquareSumW'(dosage_in == 2'd2 ? 3'd4 : {1'b0, dosage_in});
        end
      end
      if (state_r == ST_IDLE && in_acc && in_command == gcs_pkg::CMD_FINISH &&
          missing_r >= n_eff) begin
        mean_r  <= '0;
        scale_r <= '0;
      end
      if (state_r == ST_DCHK) begin
        mean_r <= (mean_q > gcs_pkg::MeanNumW'(gcs_pkg::MeanMax)) ? gcs_pkg::MeanMax
                : mean_q[gcs_pkg::MeanW-1:0];
        if (dd_nonpos) begin
          scale_r <= '0;
        end
      end
      if (state_r == ST_SCHK && dq_r[DW-1:64] != '0) begin
        scale_r <= '1;
      end
      if (state_r == ST_DSCALE && sqrt_mode_r && last_step) begin
        scale_r <= root_nxt;
      end
      if (state_r == ST_PUSH && push_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!last_step) begin
      step_r <= step_r - gcs_pkg::StepW'(1);
    end
    case (state_r)
      ST_IDLE: begin
        cnt_r        <= cnt_w;
        nm1_r        <= gcs_pkg::IdxW'(n_eff - CW'(1));
        res_kind_r   <= (in_command == gcs_pkg::CMD_READ) ? gcs_pkg::KindValue
                      : gcs_pkg::KindSummary;
        res_val_r    <= '0;
        res_status_r <= (in_command == gcs_pkg::CMD_FINISH && missing_r >= n_eff)
                      ? gcs_pkg::StatusMissing : gcs_pkg::StatusOk;
        sqrt_mode_r  <= 1'b0;
      end
      ST_RDATA: begin
        neg_r  <= rd_neg;
        mp_r   <= {{(gcs_pkg::ScaleW+1){1'b0}}, rd_mag};
        step_r <= gcs_pkg::StepW'(gcs_pkg::MeanW - 1);
      end
      ST_MUL: begin
        mp_r <= {mul_sum, mp_r[gcs_pkg::MeanW-1:1]};
      end
      ST_ROUND: begin
        res_val_r <= neg_r ? val_neg : val_pos;
      end
      ST_FPROD: begin
        prod_sq_r <= NW'(square_sum_r) * NW'(cnt_r);
        prod_as_r <= NW'(allele_sum_r) * NW'(allele_sum_r);
        num_r     <= gcs_pkg::NumW'(nm1_r) * gcs_pkg::NumW'(cnt_r);
        rem_r     <= '0;
        den_r     <= NW'({cnt_r, 1'b0});
        dq_r      <= {mean_num, {(DW - gcs_pkg::MeanNumW){1'b0}}};
        step_r    <= gcs_pkg::StepW'(gcs_pkg::MeanNumW - 1);
      end
      ST_DMEAN: begin
        rem_r <= div_rem;
        dq_r  <= {dq_r[DW-2:0], div_ge};
      end
      ST_DCHK: begin
        if (dd_nonpos) begin
          res_status_r <= gcs_pkg::StatusZeroVar;
        end
        rem_r  <= '0;
        den_r  <= dd_w[NW-1:0];
        dq_r   <= {num_r, {gcs_pkg::FracBits{1'b0}}};
        step_r <= gcs_pkg::StepW'(DW - 1);
      end
      ST_DSCALE: begin
        if (sqrt_mode_r) begin
          srem_r <= sq_ge ? (gcs_pkg::ScaleW+2)'(sq_t - sq_trial)
                          : sq_t[gcs_pkg::ScaleW+1:0];
          root_r <= root_nxt;
          dq_r   <= {dq_r[DW-3:0], 2'b00};
        end else begin
          rem_r <= div_rem;
          dq_r  <= {dq_r[DW-2:0], div_ge};
        end
      end
      ST_SCHK: begin
        sqrt_mode_r <= 1'b1;
        srem_r      <= '0;
        root_r      <= '0;
        dq_r        <= {dq_r[63:0], {(DW - 64){1'b0}}};
        step_r      <= gcs_pkg::StepW'(gcs_pkg::ScaleW - 1);
      end
      ST_PUSH: begin
        if (push_go) begin
          out_kind_r   <= res_kind_r;
          out_val_r    <= res_val_r;
          out_mean_r   <= res_kind_r ? '0 : mean_r;
          out_scale_r  <= res_kind_r ? '0 : scale_r;
          out_status_r <= res_status_r;
        end
      end
      default: begin
        rem_r <= rem_r;
      end
    endcase
  end

  assign out_valid              = out_valid_r;
  assign out_result_kind        = out_kind_r;
  assign out_standardized_value = out_val_r;
  assign out_mean_value         = out_mean_r;
  assign out_scale_value        = out_scale_r;
  assign out_status             = out_status_r;

endmodule

`default_nettype wire
